FILE: rtl/core/taf_pkg.sv
// touch accommodation filter: shared types, register codes and reset values
// no dependencies

package taf_pkg;

	localparam int TRACK_W = 3;
	localparam int STAMP_W = 32;
	localparam int POS_W   = 16;
	localparam int TIME_W  = 12;
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 3;
	localparam int THR_SQ_W = 2 * TIME_W;

	typedef enum logic [INDEX_W-1:0] {
		REG_HOLD_ENABLE    = 3'd0,
		REG_HOLD_TIME      = 3'd1,
		REG_IGNORE_ENABLE  = 3'd2,
		REG_IGNORE_TIME    = 3'd3,
		REG_TAP_MODE       = 3'd4,
		REG_TAP_TIME       = 3'd5,
		REG_MOVE_THRESHOLD = 3'd6
	} reg_index_t;

	localparam logic [MODE_W-1:0] TAP_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] TAP_INITIAL = 2'd1;
	localparam logic [MODE_W-1:0] TAP_FINAL   = 2'd2;

	localparam logic [TIME_W-1:0] HOLD_TIME_RST      = 12'd100;
	localparam logic [TIME_W-1:0] IGNORE_TIME_RST    = 12'd100;
	localparam logic [TIME_W-1:0] TAP_TIME_RST       = 12'd100;
	localparam logic [TIME_W-1:0] MOVE_THRESHOLD_RST = 12'd672;
	localparam logic [THR_SQ_W-1:0] THR_SQ_RST =
		THR_SQ_W'(MOVE_THRESHOLD_RST * MOVE_THRESHOLD_RST);

	typedef struct packed {
		logic                hold_enable;
		logic [TIME_W-1:0]   hold_time;
		logic                ignore_enable;
		logic [TIME_W-1:0]   ignore_time;
		logic [MODE_W-1:0]   tap_mode;
		logic [TIME_W-1:0]   tap_time;
		logic [THR_SQ_W-1:0] thr_sq;
	} cfg_t;

	typedef struct packed {
		logic               trial_start;
		logic [TRACK_W-1:0] track;
		logic [STAMP_W-1:0] stamp;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic               track_last;
	} sample_t;

	typedef struct packed {
		logic [TRACK_W-1:0] out_track;
		logic [STAMP_W-1:0] out_stamp;
		logic [POS_W-1:0]   out_x;
		logic [POS_W-1:0]   out_y;
	} result_t;

	typedef struct packed {
		logic               contact_active;
		logic [STAMP_W-1:0] hold_start;
		logic [POS_W-1:0]   first_x;
		logic [POS_W-1:0]   first_y;
		logic               window_open;
		logic [STAMP_W-1:0] window_start;
		logic [POS_W-1:0]   anchor_x;
		logic [POS_W-1:0]   anchor_y;
		logic [STAMP_W-1:0] release_stamp;
		logic               release_seen;
	} state_t;

endpackage

FILE: rtl/core/taf_ifs.sv
// touch accommodation filter: channel interfaces (sample in, sample out, config write)
// depends on taf_pkg

interface touch_in_if import taf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               trial_start;
	logic [TRACK_W-1:0] track;
	logic [STAMP_W-1:0] stamp;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic               track_last;

	modport source (output valid, trial_start, track, stamp, pos_x, pos_y, track_last,
		input ready);
	modport sink (input valid, trial_start, track, stamp, pos_x, pos_y, track_last,
		output ready);
endinterface

interface touch_out_if import taf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TRACK_W-1:0] out_track;
	logic [STAMP_W-1:0] out_stamp;
	logic [POS_W-1:0]   out_x;
	logic [POS_W-1:0]   out_y;

	modport source (output valid, out_track, out_stamp, out_x, out_y, input ready);
	modport sink (input valid, out_track, out_stamp, out_x, out_y, output ready);
endinterface

interface cfg_wr_if import taf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] index;
	logic [TIME_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/taf_cfg.sv
// touch accommodation filter: configuration registers, squared move threshold
// depends on taf_pkg and cfg_wr_if

module taf_cfg import taf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cfg_wr_if.sink   cfg,
	output cfg_t     regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_enable   <= 1'b0;
			regs_q.hold_time     <= HOLD_TIME_RST;
			regs_q.ignore_enable <= 1'b0;
			regs_q.ignore_time   <= IGNORE_TIME_RST;
			regs_q.tap_mode      <= TAP_OFF;
			regs_q.tap_time      <= TAP_TIME_RST;
			regs_q.thr_sq        <= THR_SQ_RST;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_HOLD_ENABLE:    regs_q.hold_enable   <= cfg.data[0];
				REG_HOLD_TIME:      regs_q.hold_time     <= cfg.data;
				REG_IGNORE_ENABLE:  regs_q.ignore_enable <= cfg.data[0];
				REG_IGNORE_TIME:    regs_q.ignore_time   <= cfg.data;
				REG_TAP_MODE:       regs_q.tap_mode      <= cfg.data[MODE_W-1:0];
				REG_TAP_TIME:       regs_q.tap_time      <= cfg.data;
				REG_MOVE_THRESHOLD: regs_q.thr_sq        <= THR_SQ_W'(cfg.data * cfg.data);
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/taf_eval.sv
// touch accommodation filter: next state and result for one sample
// ignore-repeat, hold-duration and tap assistance in one combinational pass
// depends on taf_pkg

module taf_eval import taf_pkg::*; #(
	parameter int MAX_TRACKS = 8
) (
	input  cfg_t                  regs,
	input  sample_t               smp,
	input  state_t                st,
	input  logic [MAX_TRACKS-1:0] fd,
	output state_t                st_next,
	output logic [MAX_TRACKS-1:0] fd_next,
	output logic                  emit,
	output result_t               res
);

	state_t                cur;
	logic [MAX_TRACKS-1:0] fd_cur;
	logic                  drop;
	logic                  down;
	logic                  held;
	logic                  in_win;
	logic                  far;
	logic [POS_W-1:0]      dx;
	logic [POS_W-1:0]      dy;
	logic [2*POS_W:0]      dist_sq;

	always_comb begin
		cur     = smp.trial_start ? '0 : st;
		fd_cur  = smp.trial_start ? '0 : fd;
		st_next = cur;
		fd_next = fd_cur;
		emit    = 1'b0;
		res     = '{out_track: smp.track, out_stamp: smp.stamp,
			out_x: smp.pos_x, out_y: smp.pos_y};
		down    = 1'b0;
		held    = 1'b0;
		in_win  = 1'b0;
		far     = 1'b0;
		dx      = '0;
		dy      = '0;
		dist_sq = '0;

		drop = regs.ignore_enable && cur.release_seen &&
			({1'b0, smp.stamp} < {1'b0, cur.release_stamp} + (STAMP_W+1)'(regs.ignore_time));

		if (!drop) begin
			if (!cur.contact_active) begin
				st_next.contact_active = 1'b1;
				st_next.hold_start     = smp.stamp;
				st_next.first_x        = smp.pos_x;
				st_next.first_y        = smp.pos_y;
			end
			for (int i = 0; i < MAX_TRACKS; i++) begin
				if (32'(smp.track) == i)
					fd_next[i] = !smp.track_last;
			end
			down = |fd_next;
			held = regs.hold_enable &&
				({1'b0, smp.stamp} < {1'b0, st_next.hold_start} + (STAMP_W+1)'(regs.hold_time));

			if (held) begin
				if (!down)
					st_next.contact_active = 1'b0;
			end else begin
				if (!cur.window_open) begin
					st_next.window_open  = 1'b1;
					st_next.window_start = smp.stamp;
					st_next.anchor_x     = smp.pos_x;
					st_next.anchor_y     = smp.pos_y;
				end
				in_win = {1'b0, smp.stamp} <
					{1'b0, st_next.window_start} + (STAMP_W+1)'(regs.tap_time);
				dx = (st_next.anchor_x >= smp.pos_x) ? st_next.anchor_x - smp.pos_x
					: smp.pos_x - st_next.anchor_x;
				dy = (st_next.anchor_y >= smp.pos_y) ? st_next.anchor_y - smp.pos_y
					: smp.pos_y - st_next.anchor_y;
				dist_sq = (2*POS_W+1)'(dx * dx) + (2*POS_W+1)'(dy * dy);
				far = dist_sq >= (2*POS_W+1)'(regs.thr_sq);

				case (regs.tap_mode)
					TAP_INITIAL: begin
						if (in_win) begin
							if (!down) begin
								emit      = 1'b1;
								res.out_x = st_next.first_x;
								res.out_y = st_next.first_y;
							end
						end else begin
							emit = 1'b1;
						end
					end
					TAP_FINAL: begin
						if (in_win) begin
							if (far) begin
								st_next.window_start = smp.stamp;
								st_next.anchor_x     = smp.pos_x;
								st_next.anchor_y     = smp.pos_y;
							end
							emit = !down;
						end else begin
							emit = 1'b1;
						end
					end
					default: emit = 1'b1;
				endcase

				if (!down) begin
					st_next.contact_active = 1'b0;
					st_next.window_open    = 1'b0;
					st_next.release_stamp  = smp.stamp;
					st_next.release_seen   = 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/touch_accommodation_filter_top.sv
// touch accommodation filter: top level with input register, state and result register
// depends on taf_pkg, taf_ifs, taf_cfg and taf_eval
//
//  channel   dir   transaction
//  in_ch     in    one touch sample (trial_start, track, stamp, pos_x, pos_y, track_last)
//  out_ch    out   one emitted sample (out_track, out_stamp, out_x, out_y)
//  cfg       in    one register write (index, data)
//
// one sample per cycle unless out_ch stalls; a result passes sample_s1, then res_q
// the filter state is read and rewritten while its sample is in the input register
// arst_n clears the filter state and loads register reset values
// a stalled result register holds the input register; in_ch.ready drops only then
// cfg is always ready and takes effect on the next sample

module touch_accommodation_filter_top import taf_pkg::*; #(
	parameter int MAX_TRACKS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	touch_in_if.sink   in_ch,
	touch_out_if.source out_ch,
	cfg_wr_if.sink     cfg
);

	cfg_t                  regs;
	sample_t               sample_s1;
	logic                  valid_s1;
	state_t                st_q;
	logic [MAX_TRACKS-1:0] fd_q;
	state_t                st_next;
	logic [MAX_TRACKS-1:0] fd_next;
	logic                  emit;
	result_t               res;
	result_t               res_q;
	logic                  out_valid_q;
	logic                  advance;

	taf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	taf_eval #(.MAX_TRACKS(MAX_TRACKS)) u_eval (
		.regs    (regs),
		.smp     (sample_s1),
		.st      (st_q),
		.fd      (fd_q),
		.st_next (st_next),
		.fd_next (fd_next),
		.emit    (emit),
		.res     (res)
	);

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			sample_s1 <= '{trial_start: in_ch.trial_start, track: in_ch.track,
				stamp: in_ch.stamp, pos_x: in_ch.pos_x, pos_y: in_ch.pos_y,
				track_last: in_ch.track_last};
		if (advance && emit)
			res_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			st_q        <= '0;
			fd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready)
				valid_s1 <= in_ch.valid;
			if (advance) begin
				st_q <= st_next;
				fd_q <= fd_next;
			end
			if (advance && emit)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_track = res_q.out_track;
	assign out_ch.out_stamp = res_q.out_stamp;
	assign out_ch.out_x     = res_q.out_x;
	assign out_ch.out_y     = res_q.out_y;

endmodule
